[sv/pcg32_pkg.sv]
package pcg32_pkg;

    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2   = 64'h94D049BB133111EB;
    localparam logic [63:0] RESET_STATE = 64'd6364136223846793006;

    localparam logic [2:0] OP_RAW     = 3'd0;
    localparam logic [2:0] OP_BOUNDED = 3'd1;
    localparam logic [2:0] OP_FRAC24  = 3'd2;
    localparam logic [2:0] OP_FRAC53  = 3'd3;
    localparam logic [2:0] OP_RESEED  = 3'd4;
    localparam logic [2:0] OP_CHILD   = 3'd5;

    localparam logic REG_SEED   = 1'b0;
    localparam logic REG_STREAM = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] bound;
        logic [63:0] salt;
    } request_t;

    typedef struct packed {
        logic [63:0] value;
        logic [63:0] child_sequence;
    } result_t;

    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        begin
            xs  = 32'(((old >> 18) ^ old) >> 27);
            rot = old[63:59];
            dbl = {xs, xs} >> rot;
            xsh_rr = dbl[31:0];
        end
    endfunction

endpackage

[sv/pcg32_random_generator.sv]
// channel | valid    | stall    | payload
// in      | in_valid | in_stall | in_data  (opcode, bound, salt)
// out     | out_valid| out_stall| out_data (value, child_sequence)
// one request at a time; raw/frac24 take one draw, frac53 and reseed two
// each draw is one pass of a shared 64x64 multiplier split into three 32x32 steps
// bounded draws (bound > 0) compute 2^32 mod bound and then the accepted remainder,
// plus one draw per rejection; derive child uses 4 multiplier passes
// reset restores the zero-seeded state with no clearing pass
// in_stall is high whenever a request is in progress or a result is waiting
module pcg32_random_generator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pcg32_pkg::request_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pcg32_pkg::result_t  out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data
);
    import pcg32_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DRAW, S_MUL, S_DRAWDONE, S_THR, S_MOD, S_MIXA, S_MIXB, S_DONE
    } state_t;

    state_t      state_reg;
    request_t    req_reg;
    logic [63:0] seed_reg, stream_reg, gen_reg, inc_reg;
    logic [63:0] ma_reg, mb_reg, acc_reg;
    logic [1:0]  part_reg;
    logic [2:0]  step_reg;
    logic [31:0] hi_reg, thr_reg;
    logic [32:0] rem_reg;
    logic [32:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg;
    logic        mix_sel_reg;
    result_t     out_reg;
    logic        out_valid_reg;

    logic [31:0] pa, pb;
    logic [63:0] prod, part_sum;
    logic [33:0] rsh;
    logic [33:0] rdiff;
    logic [31:0] drawn;

    always_comb
    begin
        pa = part_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb = part_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        prod = {32'd0, pa} * {32'd0, pb};
        unique case (part_reg)
            2'd0:    part_sum = prod;
            2'd1:    part_sum = {prod[31:0], 32'd0};
            2'd2:    part_sum = {prod[31:0], 32'd0};
            default: part_sum = 64'd0;
        endcase
        rsh   = {rem_reg, quo_reg[32]};
        rdiff = rsh - {2'd0, req_reg.bound};
        drawn = xsh_rr(gen_reg);
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= 64'd0;
            stream_reg    <= 64'd0;
            gen_reg       <= RESET_STATE;
            inc_reg       <= 64'd1;
            out_valid_reg <= 1'b0;
            part_reg      <= 2'd0;
            step_reg      <= 3'd0;
            cnt_reg       <= 6'd0;
            mix_sel_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_SEED)
                begin
                    seed_reg <= cfg_data;
                end
                else
                begin
                    stream_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        req_reg     <= in_data;
                        out_reg     <= '0;
                        step_reg    <= 3'd0;
                        mix_sel_reg <= 1'b0;
                        unique case (in_data.opcode)
                            OP_RAW, OP_FRAC24, OP_FRAC53:
                                state_reg <= S_DRAW;
                            OP_BOUNDED:
                            begin
                                if (in_data.bound == 32'd0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    rem_reg   <= 33'd0;
                                    quo_reg   <= {1'b1, 32'd0};
                                    cnt_reg   <= 6'd0;
                                    state_reg <= S_THR;
                                end
                            end
                            OP_RESEED:
                            begin
                                gen_reg   <= 64'd0;
                                inc_reg   <= {stream_reg[62:0], 1'b1};
                                state_reg <= S_DRAW;
                            end
                            OP_CHILD:
                            begin
                                x_reg     <= gen_reg ^ (inc_reg + GOLDEN);
                                state_reg <= S_MIXA;
                            end
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_THR:
                begin
                    // restoring division of 2^32 by bound, one bit a cycle
                    if (rdiff[33])
                    begin
                        rem_reg <= rsh[32:0];
                    end
                    else
                    begin
                        rem_reg <= rdiff[32:0];
                    end
                    quo_reg <= {quo_reg[31:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32)
                    begin
                        thr_reg   <= rdiff[33] ? rsh[31:0] : rdiff[31:0];
                        state_reg <= S_DRAW;
                    end
                end
                S_DRAW:
                begin
                    ma_reg    <= gen_reg;
                    mb_reg    <= LCG_MULT;
                    acc_reg   <= inc_reg | 64'd1;
                    part_reg  <= 2'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    acc_reg  <= acc_reg + part_sum;
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd2)
                    begin
                        state_reg <= mix_sel_reg ? S_MIXB : S_DRAWDONE;
                    end
                end
                S_DRAWDONE:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (req_reg.opcode == OP_RESEED && step_reg == 3'd0)
                    begin
                        gen_reg <= acc_reg + seed_reg;
                    end
                    else
                    begin
                        gen_reg <= acc_reg;
                    end
                    unique case (req_reg.opcode)
                        OP_RAW:
                        begin
                            out_reg.value <= {32'd0, drawn};
                            state_reg     <= S_DONE;
                        end
                        OP_FRAC24:
                        begin
                            out_reg.value <= {40'd0, drawn[31:8]};
                            state_reg     <= S_DONE;
                        end
                        OP_FRAC53:
                        begin
                            if (step_reg == 3'd0)
                            begin
                                hi_reg    <= drawn;
                                state_reg <= S_DRAW;
                            end
                            else
                            begin
                                out_reg.value <= {11'd0, hi_reg, drawn[31:11]};
                                state_reg     <= S_DONE;
                            end
                        end
                        OP_BOUNDED:
                        begin
                            if (drawn < thr_reg)
                            begin
                                state_reg <= S_DRAW;
                            end
                            else
                            begin
                                rem_reg   <= 33'd0;
                                quo_reg   <= {1'b0, drawn};
                                cnt_reg   <= 6'd0;
                                state_reg <= S_MOD;
                            end
                        end
                        OP_RESEED:
                            state_reg <= (step_reg == 3'd0) ? S_DRAW : S_DONE;
                        default:
                            state_reg <= S_DONE;
                    endcase
                end
                S_MOD:
                begin
                    if (rdiff[33])
                    begin
                        rem_reg <= rsh[32:0];
                    end
                    else
                    begin
                        rem_reg <= rdiff[32:0];
                    end
                    quo_reg <= {quo_reg[31:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32)
                    begin
                        out_reg.value <= {32'd0, rdiff[33] ? rsh[31:0] : rdiff[31:0]};
                        state_reg     <= S_DONE;
                    end
                end
                S_MIXA:
                begin
                    // steps: 0 add golden, 1 mul c1, 2 mul c2, then finish
                    mix_sel_reg <= 1'b1;
                    part_reg    <= 2'd0;
                    acc_reg     <= 64'd0;
                    unique case (step_reg[1:0])
                        2'd0:
                        begin
                            x_reg    <= x_reg + GOLDEN;
                            step_reg <= {step_reg[2], 2'd1};
                        end
                        2'd1:
                        begin
                            ma_reg    <= x_reg ^ (x_reg >> 30);
                            mb_reg    <= MIX_C1;
                            state_reg <= S_MUL;
                        end
                        default:
                        begin
                            ma_reg    <= x_reg ^ (x_reg >> 27);
                            mb_reg    <= MIX_C2;
                            state_reg <= S_MUL;
                        end
                    endcase
                end
                S_MIXB:
                begin
                    if (step_reg[1:0] == 2'd1)
                    begin
                        x_reg     <= acc_reg;
                        step_reg  <= {step_reg[2], 2'd2};
                        state_reg <= S_MIXA;
                    end
                    else if (!step_reg[2])
                    begin
                        out_reg.value <= acc_reg ^ (acc_reg >> 31);
                        x_reg         <= acc_reg ^ (acc_reg >> 31) ^ req_reg.salt;
                        step_reg      <= 3'd4;
                        state_reg     <= S_MIXA;
                    end
                    else
                    begin
                        out_reg.child_sequence <= acc_reg ^ (acc_reg >> 31) | 64'd1;
                        state_reg              <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    mix_sel_reg   <= 1'b0;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_inc_odd: assert property (@(posedge clk) disable iff (!rst_n)
        inc_reg[0])
        else $error("increment even");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result without completion");
`endif

endmodule

[sim/pcg32_random_generator_checker.sv]
`timescale 1ns / 100ps

module pcg32_random_generator_checker
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  request_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  result_t     out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    logic [63:0] seed_reg;
    logic [63:0] stream_reg;
    logic [63:0] lcg_state;
    logic [63:0] lcg_inc;
    result_t     expected_results[$];

    assign pending = expected_results.size();

    function automatic logic [31:0] permute_step();
        logic [63:0] old;
        logic [31:0] xs;
        logic [4:0]  rot;
        old = lcg_state;
        lcg_state = old * 64'd6364136223846793005 + (lcg_inc | 64'd1);
        xs = 32'(((old >> 18) ^ old) >> 27);
        rot = old[63:59];
        return (xs >> rot) | (xs << ((32 - rot) & 31));
    endfunction

    function automatic logic [63:0] splitmix(input logic [63:0] x);
        x = x + 64'h9E3779B97F4A7C15;
        x = (x ^ (x >> 30)) * 64'hBF58476D1CE4E5B9;
        x = (x ^ (x >> 27)) * 64'h94D049BB133111EB;
        return x ^ (x >> 31);
    endfunction

    function automatic void reseed_generator(input logic [63:0] s, input logic [63:0] seq);
        logic [31:0] unused;
        lcg_state = 64'd0;
        lcg_inc = {seq[62:0], 1'b1};
        unused = permute_step();
        lcg_state = lcg_state + s;
        unused = permute_step();
    endfunction

    function automatic result_t predict_result(input request_t req);
        result_t     res;
        logic [31:0] thr;
        logic [31:0] r;
        logic [63:0] hi;
        logic [63:0] s0;
        res = '0;
        case (req.opcode)
            OP_RAW: res.value = 64'(permute_step());
            OP_BOUNDED:
                if (req.bound != 0)
                begin
                    thr = 32'(64'h1_0000_0000 % {32'd0, req.bound});
                    do
                        r = permute_step();
                    while (r < thr);
                    res.value = 64'(r % req.bound);
                end
            OP_FRAC24: res.value = 64'(permute_step() >> 8);
            OP_FRAC53:
            begin
                hi = 64'(permute_step());
                res.value = ((hi << 32) | 64'(permute_step())) >> 11;
            end
            OP_RESEED: reseed_generator(seed_reg, stream_reg);
            OP_CHILD:
            begin
                s0 = splitmix(lcg_state ^ (lcg_inc + 64'h9E3779B97F4A7C15));
                res.value = s0;
                res.child_sequence = splitmix(s0 ^ req.salt) | 64'd1;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            seed_reg = '0;
            stream_reg = '0;
            reseed_generator(64'd0, 64'd0);
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SEED)
                    seed_reg = cfg_data;
                else
                    stream_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_result(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", out_data.value, 64'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.value !== want.value)
                        report_mismatch("value", out_data.value, want.value);
                    if (out_data.child_sequence !== want.child_sequence)
                        report_mismatch("child_sequence", out_data.child_sequence,
                                        want.child_sequence);
                end
            end
        end
    end

endmodule

[sim/pcg32_random_generator_test.sv]
`timescale 1ns / 100ps

module pcg32_random_generator_test;

    import pcg32_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    request_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    result_t     out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_SEED;
    logic [63:0] cfg_data = '0;
    int          mismatches;
    int          pending;
    bit          busy_mode = 1'b1;

    always #1 clk = ~clk;

    pcg32_random_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pcg32_random_generator_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // receiver stalls at random, except during the quiet stretch
    always @(posedge clk)
        out_stall <= busy_mode && ($urandom_range(99) < 38);

    task automatic send_request(input logic [2:0] op, input logic [31:0] bound,
                                input logic [63:0] salt);
        while (busy_mode && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{opcode: op, bound: bound, salt: salt};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_register(input logic idx, input logic [63:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_bound();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom_range(16);
            2: return 32'h8000_0000 + $urandom_range(1000);
            3: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [2:0] op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_request(OP_RAW, '0, '0);
        send_request(OP_BOUNDED, 32'd0, '0);
        send_request(OP_BOUNDED, 32'd1, '0);
        send_request(OP_BOUNDED, 32'd3, '1);
        send_request(OP_BOUNDED, 32'h8000_0001, '0);
        send_request(OP_BOUNDED, 32'hFFFF_FFFF, '0);
        send_request(OP_FRAC24, '1, '1);
        send_request(OP_FRAC53, '0, '0);
        send_request(OP_CHILD, '0, '0);
        send_request(OP_CHILD, '0, '1);
        send_request(3'd6, '1, '1);
        send_request(3'd7, '0, '0);
        send_request(OP_RESEED, '0, '0);
        send_request(OP_RAW, '0, '0);
        write_register(REG_SEED, '1);
        write_register(REG_STREAM, '1);
        send_request(OP_RESEED, '0, '0);
        send_request(OP_FRAC53, '0, '0);
        send_request(OP_CHILD, '0, 64'hA5A5_5A5A_0F0F_F0F0);

        for (int i = 0; i < 1750; i++)
        begin
            if (i % 300 == 0)
            begin
                write_register(REG_SEED, (i == 600) ? 64'd0 : rand64());
                write_register(REG_STREAM, (i == 900) ? 64'd0 : rand64());
            end
            busy_mode = !(i >= 1000 && i < 1200);
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
            if (op == OP_RESEED && $urandom_range(3) != 0)
                op = OP_RAW;
            send_request(op, random_bound(), rand64());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
sv/pcg32_pkg.sv
sv/pcg32_random_generator.sv
sim/pcg32_random_generator_checker.sv
sim/pcg32_random_generator_test.sv
